// ----- hw/rtl/setx_pkg.sv -----
// shared types and constants of the sprite entry tile expander
package setx_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [8:0] FLIP_X_ORIGIN = 9'd368;
  localparam logic [8:0] FLIP_Y_ORIGIN = 9'd240;
  localparam logic [8:0] TILE_PITCH    = 9'd16;
  localparam logic [9:0] X_GUARD       = 10'd16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SCREEN_FLIP    = 3'd0,
    REG_SCREEN_SHIFT   = 3'd1,
    REG_ANY_NONZERO    = 3'd2,
    REG_ENTRY_FLIP     = 3'd3,
    REG_PRIORITY_VALUE = 3'd4,
    REG_PRIORITY_MASK  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0]       tile;
    logic [15:0]       attr;
    logic signed [9:0] x;
    logic [8:0]        y;
    logic              flip;
    logic [3:0]        cols_m1;
    logic [3:0]        rows_m1;
    logic              mirror_x;
    logic              mirror_y;
  } cmd_t;

endpackage

// ----- hw/rtl/setx_front.sv -----
// front end: configuration registers, entry visibility test and position setup
module setx_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [setx_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [setx_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [15:0]                       control_word,
  input  logic [15:0]                       size_word,
  input  logic [15:0]                       first_tile,
  input  logic [15:0]                       x_word,
  input  logic [15:0]                       y_word,
  input  logic [15:0]                       attr_word,
  input  logic                              q_full,
  output logic                              q_push,
  output setx_pkg::cmd_t                    q_cmd
);
  import setx_pkg::*;

  logic       screen_flipped;
  logic [6:0] screen_shift;
  logic       any_nonzero_enable;
  logic       entry_flip_enable;
  logic [7:0] priority_value;
  logic [7:0] priority_mask;

  logic       shown;
  logic       prio_ok;
  logic [8:0] sx;
  logic [8:0] sx_f;
  logic [8:0] rx9;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_flipped     <= 1'b0;
      screen_shift       <= '0;
      any_nonzero_enable <= 1'b0;
      entry_flip_enable  <= 1'b0;
      priority_value     <= '0;
      priority_mask      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_FLIP:    screen_flipped     <= cfg_data[0];
        REG_SCREEN_SHIFT:   screen_shift       <= cfg_data[6:0];
        REG_ANY_NONZERO:    any_nonzero_enable <= cfg_data[0];
        REG_ENTRY_FLIP:     entry_flip_enable  <= cfg_data[0];
        REG_PRIORITY_VALUE: priority_value     <= cfg_data;
        REG_PRIORITY_MASK:  priority_mask      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    shown   = control_word[0] || (any_nonzero_enable && (control_word != 16'd0));
    prio_ok = ((attr_word[15:8] & priority_mask) == priority_value);
    sx      = x_word[8:0] + {2'b00, screen_shift};
    sx_f    = screen_flipped ? (FLIP_X_ORIGIN - sx) : sx;
    rx9     = sx_f + TILE_PITCH;

    q_cmd.tile     = first_tile;
    q_cmd.attr     = attr_word;
    q_cmd.x        = $signed({1'b0, rx9} - X_GUARD);
    q_cmd.y        = screen_flipped ? (FLIP_Y_ORIGIN - y_word[8:0]) : y_word[8:0];
    q_cmd.flip     = screen_flipped;
    q_cmd.cols_m1  = size_word[3:0];
    q_cmd.rows_m1  = size_word[7:4];
    q_cmd.mirror_x = entry_flip_enable ? (size_word[8] ^ screen_flipped) : screen_flipped;
    q_cmd.mirror_y = entry_flip_enable ? (size_word[9] ^ screen_flipped) : screen_flipped;
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && shown && prio_ok;

endmodule

// ----- hw/rtl/setx_queue.sv -----
// short command queue between front end and row emitter
module setx_queue #(
  parameter int unsigned DEPTH = setx_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  setx_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           nonempty,
  output setx_pkg::cmd_t head
);
  import setx_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == FULL_CNT);
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/setx_back.sv -----
// back end: walks the rows of one command and drives the output register
module setx_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_nonempty,
  input  setx_pkg::cmd_t    q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       row_tile,
  output logic [15:0]       colour,
  output logic signed [9:0] row_x,
  output logic [8:0]        row_y,
  output logic              step_negative,
  output logic [4:0]        tile_count,
  output logic              mirror_x,
  output logic              mirror_y,
  output logic              last
);
  import setx_pkg::*;

  cmd_t        cur;
  logic        busy;
  logic [3:0]  row;
  logic [15:0] tile_run;
  logic [8:0]  y_run;
  logic        advance;
  logic        finishing;
  logic [4:0]  cols;

  assign cols      = {1'b0, cur.cols_m1} + 5'd1;
  assign advance   = busy && (!out_valid || !out_stall);
  assign finishing = advance && (row == cur.rows_m1);
  assign q_pop     = q_nonempty && (!busy || finishing);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
      end else if (finishing) begin
        busy <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur      <= q_head;
      tile_run <= q_head.tile;
      y_run    <= q_head.y;
      row      <= '0;
    end else if (advance) begin
      tile_run <= tile_run + {11'd0, cols};
      y_run    <= cur.flip ? (y_run - TILE_PITCH) : (y_run + TILE_PITCH);
      row      <= row + 4'd1;
    end
    if (advance) begin
      row_tile      <= tile_run;
      colour        <= cur.attr;
      row_x         <= cur.x;
      row_y         <= y_run;
      step_negative <= cur.flip;
      tile_count    <= cols;
      mirror_x      <= cur.mirror_x;
      mirror_y      <= cur.mirror_y;
      last          <= (row == cur.rows_m1);
    end
  end

endmodule

// ----- hw/rtl/sprite_entry_tile_expander_unit.sv -----
// top level of the sprite entry tile expander
//
//   channel  handshake            payload
//   in       in_valid/in_stall    control_word size_word first_tile x_word y_word attr_word
//   out      out_valid/out_stall  row_tile colour row_x row_y step_negative tile_count
//                                 mirror_x mirror_y last
//   cfg      cfg_we               cfg_index cfg_data
//
// the row emitter gives one row transaction per cycle while out_stall is low, so an entry gives
// rows_m1+1 rows (1 to 16); a hidden entry is dropped by the front end and never queued
// entries pass through a QUEUE_DEPTH-deep queue; in_stall is high while it is full
// the first row passes the queue slot, the back end's command register and the output register
// rst clears the configuration registers, the queue and the output valid
module sprite_entry_tile_expander_unit #(
  parameter int unsigned QUEUE_DEPTH = setx_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [setx_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [setx_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [15:0]                       control_word,
  input  logic [15:0]                       size_word,
  input  logic [15:0]                       first_tile,
  input  logic [15:0]                       x_word,
  input  logic [15:0]                       y_word,
  input  logic [15:0]                       attr_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [15:0]                       row_tile,
  output logic [15:0]                       colour,
  output logic signed [9:0]                 row_x,
  output logic [8:0]                        row_y,
  output logic                              step_negative,
  output logic [4:0]                        tile_count,
  output logic                              mirror_x,
  output logic                              mirror_y,
  output logic                              last
);
  import setx_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_nonempty;
  cmd_t q_cmd;
  cmd_t q_head;

  setx_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .control_word (control_word),
    .size_word    (size_word),
    .first_tile   (first_tile),
    .x_word       (x_word),
    .y_word       (y_word),
    .attr_word    (attr_word),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_cmd)
  );

  setx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  setx_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_nonempty    (q_nonempty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .row_tile      (row_tile),
    .colour        (colour),
    .row_x         (row_x),
    .row_y         (row_y),
    .step_negative (step_negative),
    .tile_count    (tile_count),
    .mirror_x      (mirror_x),
    .mirror_y      (mirror_y),
    .last          (last)
  );

endmodule
